### hw/rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the checksummed frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfd_pkg;

  // Framing bytes
  localparam logic [7:0] StartZero = 8'h00;
  localparam logic [7:0] StartFf   = 8'hFF;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT0  = 6'b000001,
    PH_HUNTFF = 6'b000010,
    PH_LEN    = 6'b000100,
    PH_LCS    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DCS    = 6'b100000
  } phase_e;

  // Result word kind
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

endpackage

### hw/rtl/checksummed_frame_deframer.sv
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Hunts 00 FF start codes, checks the length checksum, streams payload words
// with their index and closes each nonempty frame with a good/bad checksum word.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes the input register, then the result
//   register, which holds its result word if the word yields one.
// Throughput: one word per cycle while no result word is stalled; the phase
//   update is one short step between the registers, so back-to-back words are taken.
// Reset: rst_ni clears the parser to hunting the first 0x00 and empties both
//   stages; payload registers are not reset.
`timescale 1ns / 1ps

module checksummed_frame_deframer import cfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] out_index_o,
  output logic [7:0] frame_length_o
);

  // Input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Parser state
  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_q, count_d;
  logic [7:0] len_q, len_d;

  // Result stage
  logic       out_vld_q;
  kind_e      kind_q, kind_d;
  logic [7:0] obyte_q, obyte_d;
  logic [7:0] oidx_q, oidx_d;
  logic [7:0] olen_q;
  logic       emit_d;

  logic       out_free;
  logic       adv;
  logic       in_take;
  logic [7:0] left_dec;
  logic [7:0] sum_add;

  // Handshake: the input stage moves on whenever the result register is free
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign left_dec = left_q - 8'd1;
  assign sum_add  = sum_q + in_byte_q;

  // Frame parser step
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    sum_d   = sum_q;
    count_d = count_q;
    len_d   = len_q;
    emit_d  = 1'b0;
    kind_d  = KIND_PAYLOAD;
    obyte_d = 8'h00;
    oidx_d  = 8'h00;
    case (phase_q)
      PH_HUNTFF: begin
        if (in_byte_q == StartFf) begin
          phase_d = PH_LEN;
        end else if (in_byte_q != StartZero) begin
          phase_d = PH_HUNT0;
        end
      end
      PH_LEN: begin
        len_d   = in_byte_q;
        phase_d = PH_LCS;
      end
      PH_LCS: begin
        if (8'(len_q + in_byte_q) == 8'h00) begin
          left_d  = len_q;
          sum_d   = 8'h00;
          count_d = 8'h00;
          phase_d = (len_q == 8'h00) ? PH_HUNTFF : PH_DATA;
        end else begin
          phase_d = PH_HUNT0;
        end
      end
      PH_DATA: begin
        emit_d  = 1'b1;
        kind_d  = KIND_PAYLOAD;
        obyte_d = in_byte_q;
        oidx_d  = count_q;
        count_d = count_q + 8'd1;
        sum_d   = sum_add;
        left_d  = left_dec;
        if (left_dec == 8'h00) begin
          phase_d = PH_DCS;
        end
      end
      PH_DCS: begin
        emit_d  = 1'b1;
        sum_d   = sum_add;
        kind_d  = (sum_add == 8'h00) ? KIND_GOOD : KIND_BAD;
        phase_d = PH_HUNT0;
      end
      default: begin
        // first-zero hunt
        phase_d = (in_byte_q == StartZero) ? PH_HUNTFF : PH_HUNT0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_HUNT0;
      left_q    <= 8'h00;
      sum_q     <= 8'h00;
      count_q   <= 8'h00;
      len_q     <= 8'h00;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        phase_q   <= phase_d;
        left_q    <= left_d;
        sum_q     <= sum_d;
        count_q   <= count_d;
        len_q     <= len_d;
        out_vld_q <= emit_d;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (adv && emit_d) begin
      kind_q  <= kind_d;
      obyte_q <= obyte_d;
      oidx_q  <= oidx_d;
      olen_q  <= len_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_kind_o     = kind_q;
  assign out_byte_o     = obyte_q;
  assign out_index_o    = oidx_q;
  assign frame_length_o = olen_q;

endmodule

### hw/rtl/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks for the checksummed frame deframer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfd_checker import cfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic [7:0] out_index_o,
  input logic [7:0] frame_length_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o)
      && $stable(out_byte_o) && $stable(out_index_o) && $stable(frame_length_o))
    else $error("result word changed while stalled");

  // Only the three defined kinds appear
  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == KIND_PAYLOAD || out_kind_o == KIND_GOOD
      || out_kind_o == KIND_BAD))
    else $error("undefined result kind");

  // End words carry zero byte and index
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_PAYLOAD |-> out_byte_o == 8'h00
      && out_index_o == 8'h00)
    else $error("end word with nonzero byte or index");

  // Payload index stays inside the announced length
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_PAYLOAD |-> out_index_o < frame_length_o)
    else $error("payload index beyond frame length");

  // Only frames with a nonzero length produce words
  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o != 8'h00)
    else $error("result word from zero-length frame");

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_kind_o     (out_kind_o),
  .out_byte_o     (out_byte_o),
  .out_index_o    (out_index_o),
  .frame_length_o (frame_length_o)
);

### tb/tb_checksummed_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_checksummed_frame_deframer
// Feeds raw link bytes into the deframer: mostly well-formed frames with
// random payload, plus acknowledge frames, length checksum errors, broken
// start codes and noise. A per-byte predictor tracks the parser and
// every result word is checked field by field against it, in order.
// Both sides idle at random, with one stretch of full-rate traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checksummed_frame_deframer;
  import cfd_pkg::*;

  // One expected result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] flen;
  } deframe_word_t;

  localparam int unsigned TargetWords = 1600;
  localparam int unsigned IdlePct     = 28;
  localparam int unsigned CalmStart   = 1200;
  localparam int unsigned CalmEnd     = 2000;
  localparam int unsigned MaxPrints   = 30;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [7:0] out_index;
  logic [7:0] frame_length;

  checksummed_frame_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_kind_o    (out_kind),
    .out_byte_o    (out_byte),
    .out_index_o   (out_index),
    .frame_length_o(frame_length)
  );

  // Stimulus and expectation stores
  logic [7:0]    pending_rx[$];
  deframe_word_t expected_words[$];

  // Parser copy used for prediction
  phase_e     parse_phase = PH_HUNT0;
  logic [7:0] bytes_due   = 8'h00;
  logic [7:0] pay_sum     = 8'h00;
  logic [7:0] pay_idx     = 8'h00;
  logic [7:0] ann_len     = 8'h00;

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned fed_cnt;
  int unsigned accepted_cnt;
  int unsigned payload_cnt;
  int unsigned good_cnt;
  int unsigned bad_cnt;

  // Directed opening: extremes, bad checksum, extra zeros, broken start,
  // length checksum error, acknowledge followed by a resumed frame
  logic [7:0] directed_seq [29] = '{
    StartZero, StartFf, 8'h01, 8'hFF, 8'hFF, 8'h01,
    StartZero, StartZero, StartFf, 8'h02, 8'hFE, 8'h00, 8'h80, 8'h7F,
    StartZero, 8'h55,
    StartZero, StartFf, 8'h03, 8'h00,
    StartZero, StartFf, 8'h00, 8'h00, StartFf, 8'h01, 8'hFF, 8'hAA, 8'h56
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Random idle decision, off during the calm window
  function automatic bit idle_now();
    if (cycle_cnt >= CalmStart && cycle_cnt < CalmEnd) return 1'b0;
    return $urandom_range(0, 99) < IdlePct;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic push_rx(input logic [7:0] v, input bit counted);
    pending_rx.push_back(v);
    if (counted) fed_cnt++;
  endtask

  // Frame with lead_zeros start zeros (none only right after an ack)
  task automatic add_frame(input int len, input int lead_zeros, input bit good_dcs);
    logic [7:0] s;
    logic [7:0] v;
    s = 8'h00;
    repeat (lead_zeros) push_rx(StartZero, 1'b1);
    push_rx(StartFf, 1'b1);
    push_rx(8'(len), 1'b1);
    push_rx(8'(-len), 1'b1);
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom_range(0, 255));
      s = s + v;
      push_rx(v, 1'b1);
    end
    if (good_dcs) push_rx(-s, 1'b1);
    else push_rx(8'(-s) + 8'($urandom_range(1, 255)), 1'b1);
  endtask

  // Parser prediction for one accepted word
  task automatic predict_rx(input logic [7:0] rx);
    deframe_word_t w;
    logic [7:0] lcs_sum;
    w = '0;
    case (parse_phase)
      PH_HUNTFF: begin
        if (rx == StartFf) parse_phase = PH_LEN;
        else if (rx != StartZero) parse_phase = PH_HUNT0;
      end
      PH_LEN: begin
        ann_len = rx;
        parse_phase = PH_LCS;
      end
      PH_LCS: begin
        lcs_sum = ann_len + rx;
        if (lcs_sum == 8'h00) begin
          bytes_due = ann_len;
          pay_sum = 8'h00;
          pay_idx = 8'h00;
          if (ann_len == 8'h00) parse_phase = PH_HUNTFF;
          else parse_phase = PH_DATA;
        end else begin
          parse_phase = PH_HUNT0;
        end
      end
      PH_DATA: begin
        w.kind = KIND_PAYLOAD;
        w.data = rx;
        w.idx  = pay_idx;
        w.flen = ann_len;
        expected_words.push_back(w);
        pay_idx = pay_idx + 8'h01;
        pay_sum = pay_sum + rx;
        bytes_due = bytes_due - 8'h01;
        if (bytes_due == 8'h00) parse_phase = PH_DCS;
      end
      PH_DCS: begin
        pay_sum = pay_sum + rx;
        if (pay_sum == 8'h00) w.kind = KIND_GOOD;
        else w.kind = KIND_BAD;
        w.flen = ann_len;
        expected_words.push_back(w);
        parse_phase = PH_HUNT0;
      end
      default: begin
        if (rx == StartZero) parse_phase = PH_HUNTFF;
        else parse_phase = PH_HUNT0;
      end
    endcase
  endtask

  // Compare the accepted result word with the oldest expectation
  task automatic check_word();
    deframe_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind=%0d byte=%02h index=%0d",
                                out_kind, out_byte, out_index));
    end else begin
      w = expected_words.pop_front();
      if (out_kind !== w.kind)
        report_mismatch($sformatf("kind %0d, want %0d", out_kind, w.kind));
      if (out_byte !== w.data)
        report_mismatch($sformatf("byte %02h, want %02h", out_byte, w.data));
      if (out_index !== w.idx)
        report_mismatch($sformatf("index %0d, want %0d", out_index, w.idx));
      if (frame_length !== w.flen)
        report_mismatch($sformatf("length %0d, want %0d", frame_length, w.flen));
      case (w.kind)
        KIND_PAYLOAD: payload_cnt++;
        KIND_GOOD:    good_cnt++;
        default:      bad_cnt++;
      endcase
    end
  endtask

  // Driver: predict on acceptance, then present the next word or idle
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rx(rx_byte);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_rx.size() > 0 && !idle_now()) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_rx.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted results, stall at random
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_word();
      out_stall <= idle_now();
    end
  end

  // Stimulus and end of run
  initial begin
    int pick;
    int len;
    int frame_no;
    int wait_cnt;
    frame_no = 0;

    foreach (directed_seq[i]) push_rx(directed_seq[i], 1'b1);

    while (fed_cnt < TargetWords) begin
      pick = $urandom_range(0, 99);
      frame_no++;
      if (pick < 70) begin
        // regular frame, mostly short, a few long
        if (frame_no == 10) len = 255;
        else if ($urandom_range(0, 99) < 3) len = $urandom_range(100, 255);
        else len = $urandom_range(1, 16);
        add_frame(len, $urandom_range(1, 4), $urandom_range(0, 99) < 75);
      end else if (pick < 78) begin
        // acknowledge, sometimes followed directly by a resumed frame
        push_rx(StartZero, 1'b1);
        push_rx(StartFf, 1'b1);
        push_rx(8'h00, 1'b1);
        push_rx(8'h00, 1'b1);
        if ($urandom_range(0, 1)) begin
          add_frame($urandom_range(1, 8), 0, $urandom_range(0, 99) < 75);
        end
      end else if (pick < 85) begin
        // length checksum error
        len = $urandom_range(0, 255);
        push_rx(StartZero, 1'b1);
        push_rx(StartFf, 1'b1);
        push_rx(8'(len), 1'b1);
        push_rx(8'(-len) + 8'($urandom_range(1, 255)), 1'b1);
      end else if (pick < 90) begin
        // start code broken by a stray byte
        push_rx(StartZero, 1'b1);
        push_rx(8'($urandom_range(1, 254)), 1'b1);
      end else begin
        // line noise
        repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_rx.size() > 0 || in_valid) @(posedge clk_i);
    wait_cnt = 0;
    while (expected_words.size() > 0 && wait_cnt < 2000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_words.size() > 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));

    $display("Sent %0d link bytes; checked %0d payload words", accepted_cnt, payload_cnt);
    $display("Frame ends checked: %0d good, %0d bad; %0d errors", good_cnt, bad_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_checksummed_frame_deframer: PASS");
    end else begin
      $display("tb_checksummed_frame_deframer: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timeout: run did not finish");
    $display("tb_checksummed_frame_deframer: FAIL");
    $finish;
  end

endmodule
